[design/assert_macros.svh]
// Assertion macros shared by the uv sphere vertex generator RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UVS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UVS_ASSERT(label, clk, rst_n, prop, msg)
`define UVS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[design/uvs_pkg.sv]
// Package for the uv sphere vertex generator: constants, types and tables.
// No dependencies.
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int MAX_DIVISIONS = 256;
  localparam int CORDIC_STEPS  = 16;
  localparam int DIV_W         = $clog2(MAX_DIVISIONS + 1);
  localparam int TEX_BITS      = 16;
  localparam int CW            = 34;
  localparam int STEP_W        = 5;
  localparam int MUL_OPS       = 6;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] RAD_SCALE   = 32'd3373259426;

  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;
  localparam logic [1:0] REG_INWARD  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_U, S_DIV_V, S_ANG_T, S_COR_T, S_ANG_P, S_COR_P, S_MUL_WB
  } uvs_state_t;

  typedef struct packed {
    logic              load_in;
    logic              div_step;
    logic              div_last;
    logic              div_sel_v;
    logic              cor_init;
    logic              cor_step;
    logic              cor_last;
    logic              cor_sel_p;
    logic              mul_en;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } uvs_cmd_t;

  typedef struct packed {
    logic out_free;
  } uvs_status_t;

  typedef struct packed {
    logic [15:0] radius;
    logic [8:0]  columns;
    logic [8:0]  rows;
    logic        inward;
  } uvs_cfg_t;

  function automatic logic [DIV_W-1:0] eff_div(input logic [8:0] d);
    if (d == 9'd0) return DIV_W'(1);
    if (int'(d) > MAX_DIVISIONS) return DIV_W'(MAX_DIVISIONS);
    return DIV_W'(d);
  endfunction

  // atan(2^-i) in Q1.30.
  function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return signed'(CW'(v));
  endfunction

endpackage

[design/uvs_if.sv]
// Handshake channel interfaces for the grid point input and the vertex output.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] grid_row;
  logic [8:0] grid_column;
  logic       restart_extent;
  modport source (output valid, grid_row, grid_column, restart_extent, input ready);
  modport sink (input valid, grid_row, grid_column, restart_extent, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic [16:0]        vertex_index;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic signed [16:0] extent_x;
  logic signed [16:0] extent_y;
  logic signed [16:0] extent_z;
  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, normal_x, normal_y,
                  normal_z, tex_u, tex_v, extent_x, extent_y, extent_z, input ready);
  modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, normal_x, normal_y,
                normal_z, tex_u, tex_v, extent_x, extent_y, extent_z, output ready);
endinterface

[design/uvs_ctrl.sv]
// Controller state machine of the uv sphere vertex generator.
// Depends on uvs_pkg; drives the datapath through uvs_cmd_t.
`timescale 1ns / 1ps
module uvs_ctrl
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  uvs_status_t status,
  output uvs_cmd_t    cmd
);

  uvs_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + STEP_W'(1);
    cmd       = '0;
    cmd.step  = cnt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DIV_U;
        end
      end
      S_DIV_U: begin
        cmd.div_step = 1'b1;
        if (cnt_r == STEP_W'(TEX_BITS - 1)) begin
          cmd.div_last = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV_V;
        end
      end
      S_DIV_V: begin
        cmd.div_step  = 1'b1;
        cmd.div_sel_v = 1'b1;
        if (cnt_r == STEP_W'(TEX_BITS - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_ANG_T;
        end
      end
      S_ANG_T: begin
        cmd.cor_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_COR_T;
      end
      S_COR_T: begin
        cmd.cor_step = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          cmd.cor_last = 1'b1;
          state_nxt    = S_ANG_P;
        end
      end
      S_ANG_P: begin
        cmd.cor_init  = 1'b1;
        cmd.cor_sel_p = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_COR_P;
      end
      S_COR_P: begin
        cmd.cor_step  = 1'b1;
        cmd.cor_sel_p = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          cmd.cor_last = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_MUL_WB;
        end
      end
      S_MUL_WB: begin
        if (cnt_r < STEP_W'(MUL_OPS)) begin
          cmd.mul_en = 1'b1;
        end else begin
          cnt_nxt = cnt_r;
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[design/uvs_datapath.sv]
// Datapath of the uv sphere vertex generator: divider, CORDIC, multiplier, output register.
// Depends on uvs_pkg and uvs_out_if; commanded by uvs_ctrl.
`timescale 1ns / 1ps
module uvs_datapath
  import uvs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  uvs_cmd_t        cmd,
  input  uvs_cfg_t        cfg,
  input  logic [8:0]      grid_row,
  input  logic [8:0]      grid_column,
  input  logic            restart_extent,
  output uvs_status_t     status,
  uvs_out_if.source       out_ch
);

  localparam logic signed [2*CW-1:0] P_ROUND = (2*CW)'(64'd536870912);
  localparam logic signed [2*CW-1:0] P_HI    = (2*CW)'(64'd65535);
  localparam logic signed [2*CW-1:0] P_LO    = -P_HI;
  localparam logic signed [CW:0]     N_HI    = (CW+1)'(16384);
  localparam logic signed [CW:0]     N_LO    = -N_HI;
  localparam int                     VI_W    = 2 * DIV_W + 2;

  function automatic logic signed [15:0] to_normal(input logic signed [CW-1:0] d,
                                                   input logic inward);
    logic signed [CW:0] t;
    logic signed [15:0] n;
    t = ((CW+1)'(d) + (CW+1)'(32768)) >>> 16;
    if (t > N_HI) n = 16'sd16384;
    else if (t < N_LO) n = -16'sd16384;
    else n = t[15:0];
    return inward ? -n : n;
  endfunction

  function automatic logic [16:0] mag(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  logic [DIV_W-1:0] cols_e, rows_e, den;
  logic [DIV_W-1:0] row_r, col_r, row_c, col_c;
  logic             restart_r;

  assign cols_e = eff_div(cfg.columns);
  assign rows_e = eff_div(cfg.rows);

  always_comb begin
    row_c = (int'(grid_row) > int'(rows_e)) ? rows_e : DIV_W'(grid_row);
    col_c = (int'(grid_column) > int'(cols_e)) ? cols_e : DIV_W'(grid_column);
  end

  // Restoring divider, one quotient bit a cycle. The numerator never exceeds
  // the divisor, so equality gives exactly one and is flagged up front.
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [TEX_BITS-1:0] q_r, q_nxt;
  logic                full_r;
  logic [DIV_W:0]      trial;
  logic                ge;
  logic [16:0]         quot;
  logic [16:0]         tu_r, tv_r;

  always_comb begin
    den     = cmd.div_sel_v ? rows_e : cols_e;
    trial   = {rem_r, 1'b0};
    ge      = trial >= {1'b0, den};
    rem_nxt = ge ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
    q_nxt   = {q_r[TEX_BITS-2:0], ge};
    quot    = full_r ? 17'h10000 : {1'b0, q_nxt};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      row_r     <= row_c;
      col_r     <= col_c;
      restart_r <= restart_extent;
      rem_r     <= col_c;
      full_r    <= (col_c == cols_e);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (cmd.div_last) begin
        if (cmd.div_sel_v) begin
          tv_r <= quot;
        end else begin
          tu_r   <= quot;
          rem_r  <= row_r;
          full_r <= (row_r == rows_e);
        end
      end
    end
  end

  // CORDIC rotation unit, shared by the polar and azimuth angles.
  logic [16:0]           ang;
  logic [46:0]           zprod;
  logic [1:0]            quad_r;
  logic signed [CW-1:0]  x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, xs, ys;
  logic signed [CW-1:0]  c_map, s_map;
  logic signed [CW-1:0]  ct_r, st_r, cp_r, sp_r;

  always_comb begin
    ang   = cmd.cor_sel_p ? {tu_r[15:0], 1'b0} : tv_r;
    zprod = 47'(ang[14:0]) * 47'(RAD_SCALE) + 47'd32768;
    xs    = x_r >>> cmd.step;
    ys    = y_r >>> cmd.step;
    if (!z_r[CW-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_q30(cmd.step);
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_q30(cmd.step);
    end
    case (quad_r)
      2'd0:    begin c_map = x_nxt;  s_map = y_nxt;  end
      2'd1:    begin c_map = -y_nxt; s_map = x_nxt;  end
      2'd2:    begin c_map = -x_nxt; s_map = -y_nxt; end
      default: begin c_map = y_nxt;  s_map = -x_nxt; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cor_init) begin
      quad_r <= ang[16:15];
      x_r    <= signed'(CW'(CORDIC_GAIN));
      y_r    <= '0;
      z_r    <= signed'(CW'(zprod[46:16]));
    end else if (cmd.cor_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (cmd.cor_last) begin
        if (cmd.cor_sel_p) begin
          cp_r <= c_map;
          sp_r <= s_map;
        end else begin
          ct_r <= c_map;
          st_r <= s_map[CW-1] ? '0 : s_map;
        end
      end
    end
  end

  // Shared multiplier: two direction products, then three radius products.
  // Each product is consumed in the cycle after it is registered.
  logic signed [CW-1:0]   mul_a, mul_b, rad_s, d0_r, d2_r;
  logic signed [2*CW-1:0] prod_r, pshift;
  logic signed [16:0]     pos_c, p0_r, p1_r, p2_r;

  always_comb begin
    rad_s = signed'(CW'(cfg.radius));
    case (cmd.step)
      5'd0:    begin mul_a = cp_r;  mul_b = st_r; end
      5'd1:    begin mul_a = sp_r;  mul_b = st_r; end
      5'd2:    begin mul_a = rad_s; mul_b = ct_r; end
      5'd3:    begin mul_a = rad_s; mul_b = d0_r; end
      5'd4:    begin mul_a = rad_s; mul_b = d2_r; end
      default: begin mul_a = '0;    mul_b = '0;   end
    endcase
    pshift = (prod_r + P_ROUND) >>> 30;
    if (pshift > P_HI) pos_c = 17'sd65535;
    else if (pshift < P_LO) pos_c = -17'sd65535;
    else pos_c = pshift[16:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
      case (cmd.step)
        5'd1:    d0_r <= CW'(prod_r >>> 30);
        5'd2:    d2_r <= CW'(prod_r >>> 30);
        5'd3:    p1_r <= pos_c;
        5'd4:    p0_r <= pos_c;
        5'd5:    p2_r <= pos_c;
        default: ;
      endcase
    end
  end

  // Running extent and the output register.
  logic signed [16:0] far_x_r, far_y_r, far_z_r;
  logic signed [16:0] bx, by, bz, fx_nxt, fy_nxt, fz_nxt;
  logic [VI_W-1:0]    vidx;
  logic               out_valid_r;

  always_comb begin
    bx     = restart_r ? '0 : far_x_r;
    by     = restart_r ? '0 : far_y_r;
    bz     = restart_r ? '0 : far_z_r;
    fx_nxt = (mag(p0_r) > mag(bx)) ? p0_r : bx;
    fy_nxt = (mag(p1_r) > mag(by)) ? p1_r : by;
    fz_nxt = (mag(p2_r) > mag(bz)) ? p2_r : bz;
    vidx   = VI_W'(row_r) * (VI_W'(cols_e) + VI_W'(1)) + VI_W'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_x_r     <= '0;
      far_y_r     <= '0;
      far_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      far_x_r     <= fx_nxt;
      far_y_r     <= fy_nxt;
      far_z_r     <= fz_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.vertex_index <= vidx[16:0];
      out_ch.pos_x        <= p0_r;
      out_ch.pos_y        <= p1_r;
      out_ch.pos_z        <= p2_r;
      out_ch.normal_x     <= to_normal(d0_r, cfg.inward);
      out_ch.normal_y     <= to_normal(ct_r, cfg.inward);
      out_ch.normal_z     <= to_normal(d2_r, cfg.inward);
      out_ch.tex_u        <= tu_r;
      out_ch.tex_v        <= tv_r;
      out_ch.extent_x     <= fx_nxt;
      out_ch.extent_y     <= fy_nxt;
      out_ch.extent_z     <= fz_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign status.out_free = !out_valid_r || out_ch.ready;

endmodule

[design/uv_sphere_vertex_generator.sv]
// Top level of the uv sphere vertex generator: configuration registers and wiring.
// Depends on uvs_pkg, uvs_if, uvs_ctrl, uvs_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// This block turns one grid point (row, column) of a latitude-longitude sphere
// into a full vertex: linear index, texture u and v in Q1.16, unit normal in
// Q2.14 and position in Q8.8, plus the running per-axis extent of positions.
// One input beat is taken at a time, and a new one is accepted only once the
// previous vertex has been written to the output register. The steps are: an
// idle state to accept, u and v on a shared restoring divider that makes one
// quotient bit a cycle, the polar and azimuth angles on a shared CORDIC unit,
// each with a setup state before the rotation steps, the direction and position
// products on a single shared multiplier, and a write of the result. If the
// output register still holds an untaken vertex, the block stalls in the
// write-back state until it frees.
// A finished vertex waits in the output register while the next grid point is
// being accepted and processed. Rows and columns beyond the configured
// divisions are clamped, and a division register of zero acts as one.
// Registers are written through the APB-style port at byte offsets 0
// (radius), 4 (columns), 8 (rows) and 12 (inward normals) and should only be
// changed while the block is idle.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  uvs_in_if.sink      in_ch,
  uvs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  uvs_cfg_t    cfg_r;
  uvs_cmd_t    cmd;
  uvs_status_t status;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius  <= 16'd256;
      cfg_r.columns <= 9'd16;
      cfg_r.rows    <= 9'd16;
      cfg_r.inward  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RADIUS:  cfg_r.radius  <= pwdata[15:0];
        REG_COLUMNS: cfg_r.columns <= pwdata[8:0];
        REG_ROWS:    cfg_r.rows    <= pwdata[8:0];
        REG_INWARD:  cfg_r.inward  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS:  prdata = {16'd0, cfg_r.radius};
      REG_COLUMNS: prdata = {23'd0, cfg_r.columns};
      REG_ROWS:    prdata = {23'd0, cfg_r.rows};
      REG_INWARD:  prdata = {31'd0, cfg_r.inward};
      default:     prdata = '0;
    endcase
  end

  uvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  uvs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg_r),
    .grid_row       (in_ch.grid_row),
    .grid_column    (in_ch.grid_column),
    .restart_extent (in_ch.restart_extent),
    .status         (status),
    .out_ch         (out_ch)
  );

  // Magnitudes for the extent check: the reported extent must dominate the
  // position of the same vertex on every axis.
  logic [16:0] px_m, py_m, pz_m, ex_m, ey_m, ez_m;
  logic        in_beat;

  assign px_m    = out_ch.pos_x[16] ? 17'(-out_ch.pos_x) : 17'(out_ch.pos_x);
  assign py_m    = out_ch.pos_y[16] ? 17'(-out_ch.pos_y) : 17'(out_ch.pos_y);
  assign pz_m    = out_ch.pos_z[16] ? 17'(-out_ch.pos_z) : 17'(out_ch.pos_z);
  assign ex_m    = out_ch.extent_x[16] ? 17'(-out_ch.extent_x) : 17'(out_ch.extent_x);
  assign ey_m    = out_ch.extent_y[16] ? 17'(-out_ch.extent_y) : 17'(out_ch.extent_y);
  assign ez_m    = out_ch.extent_z[16] ? 17'(-out_ch.extent_z) : 17'(out_ch.extent_z);
  assign in_beat = in_ch.valid && in_ch.ready;

  `UVS_ASSERT(a_one_item_at_a_time, clk, rst_n, in_beat |=> !in_ch.ready, "input taken while busy")
  `UVS_ASSERT(a_extent_covers_pos, clk, rst_n, out_ch.valid |-> (ex_m >= px_m && ey_m >= py_m && ez_m >= pz_m), "extent below position")
  `UVS_ASSERT(a_normal_bounded, clk, rst_n, out_ch.valid |-> (out_ch.normal_x <= 16'sd16384 && out_ch.normal_x >= -16'sd16384 && out_ch.normal_y <= 16'sd16384 && out_ch.normal_y >= -16'sd16384), "normal out of range")

endmodule

[tb/sv/uvs_vertex_checker.sv]
// Checker for the uv sphere vertex generator: watches both channels and the register port.
// Depends on uvs_pkg and uvs_if; predicts each vertex and compares it with the output beat.
`timescale 1ns / 1ps
module uvs_vertex_checker
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  uvs_in_if           in_mon,
  uvs_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          vertices_pending,
  output int          vertices_checked
);

  typedef struct {
    longint idx;
    longint px, py, pz;
    longint nx, ny, nz;
    longint u, v;
    longint ex, ey, ez;
  } vertex_t;

  localparam longint ARC_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic [15:0] radius_q;
  logic [8:0]  columns_q;
  logic [8:0]  rows_q;
  logic        inward_q;
  longint      far_x, far_y, far_z;
  vertex_t     vertex_q[$];

  function automatic longint clip(input longint val, input longint lo, input longint hi);
    return val < lo ? lo : (val > hi ? hi : val);
  endfunction

  function automatic longint span(input logic [8:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIVISIONS) return MAX_DIVISIONS;
    return d;
  endfunction

  // Angle in 2^-17 turn; cosine and sine in Q1.30.
  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [1:0]      quad;
    longint unsigned res;
    longint          z, x, y, xn;
    quad = ang[16:15];
    res  = ang[14:0];
    z = longint'((res * 64'd3373259426 + 64'd32768) >> 16);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARC_TAB[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARC_TAB[i];
      end
      x = xn;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic void keep_far(ref longint far, input longint p);
    longint ap, af;
    ap = p < 0 ? -p : p;
    af = far < 0 ? -far : far;
    if (ap > af) far = p;
  endfunction

  function automatic vertex_t build_vertex(input logic [8:0] row_in, input logic [8:0] col_in,
                                           input logic restart);
    vertex_t vx;
    longint  cols, rows, row, col, ct, st, cp, sp;
    longint  dir [3];
    longint  nrm [3];
    longint  pos [3];
    cols = span(columns_q);
    rows = span(rows_q);
    row  = row_in > rows ? rows : row_in;
    col  = col_in > cols ? cols : col_in;
    if (restart) begin
      far_x = 0; far_y = 0; far_z = 0;
    end
    vx.u = (col << 16) / cols;
    vx.v = (row << 16) / rows;
    rotate(32'(vx.v), ct, st);
    rotate(32'(vx.u * 2), cp, sp);
    if (st < 0) st = 0;
    dir[0] = (cp * st) >>> 30;
    dir[1] = ct;
    dir[2] = (sp * st) >>> 30;
    for (int k = 0; k < 3; k++) begin
      nrm[k] = clip((dir[k] + 32768) >>> 16, -16384, 16384);
      if (inward_q) nrm[k] = -nrm[k];
      pos[k] = clip((longint'(radius_q) * dir[k] + (64'sd1 <<< 29)) >>> 30, -65535, 65535);
    end
    keep_far(far_x, pos[0]);
    keep_far(far_y, pos[1]);
    keep_far(far_z, pos[2]);
    vx.idx = (row * (cols + 1) + col) & 64'h1FFFF;
    vx.px = pos[0]; vx.py = pos[1]; vx.pz = pos[2];
    vx.nx = nrm[0]; vx.ny = nrm[1]; vx.nz = nrm[2];
    vx.ex = far_x; vx.ey = far_y; vx.ez = far_z;
    return vx;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (!rst_n) begin
      radius_q <= 16'd256;
      columns_q <= 9'd16;
      rows_q <= 9'd16;
      inward_q <= 1'b0;
      far_x = 0; far_y = 0; far_z = 0;
      vertex_q.delete();
      mismatch_count = 0;
      vertices_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RADIUS:  radius_q <= pwdata[15:0];
          REG_COLUMNS: columns_q <= pwdata[8:0];
          REG_ROWS:    rows_q <= pwdata[8:0];
          REG_INWARD:  inward_q <= pwdata[0];
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        vertex_q.push_back(build_vertex(in_mon.grid_row, in_mon.grid_column,
                                        in_mon.restart_extent));
      if (out_mon.valid && out_mon.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex beat arrived with no grid point outstanding");
          mismatch_count++;
        end else begin
          want = vertex_q.pop_front();
          vertices_checked++;
          check_field("vertex_index", want.idx, longint'(out_mon.vertex_index));
          check_field("pos_x", want.px, longint'(out_mon.pos_x));
          check_field("pos_y", want.py, longint'(out_mon.pos_y));
          check_field("pos_z", want.pz, longint'(out_mon.pos_z));
          check_field("normal_x", want.nx, longint'(out_mon.normal_x));
          check_field("normal_y", want.ny, longint'(out_mon.normal_y));
          check_field("normal_z", want.nz, longint'(out_mon.normal_z));
          check_field("tex_u", want.u, longint'(out_mon.tex_u));
          check_field("tex_v", want.v, longint'(out_mon.tex_v));
          check_field("extent_x", want.ex, longint'(out_mon.extent_x));
          check_field("extent_y", want.ey, longint'(out_mon.extent_y));
          check_field("extent_z", want.ez, longint'(out_mon.extent_z));
        end
      end
    end
    vertices_pending = vertex_q.size();
  end

endmodule

[tb/sv/tb_uv_sphere_vertex_generator.sv]
// Top of the uv sphere vertex generator testbench: clock, reset, stimulus and verdict.
// Depends on uvs_pkg, uvs_if, uvs_vertex_checker and the generator itself.
`timescale 1ns / 1ps
module tb_uv_sphere_vertex_generator
  import uvs_pkg::*;
;

  // Cycles without any accepted beat or register access before the run is
  // declared hung, with a wide margin for random stalls.
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int POINTS_PER_PHASE = 275;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          vertices_pending;
  int          vertices_checked;
  int          hang_cycles = 0;
  bit          steady;

  // Shadow of the division registers, used only to aim the grid points.
  int          rows_used;
  int          cols_used;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  uv_sphere_vertex_generator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  uvs_vertex_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .vertices_pending (vertices_pending),
    .vertices_checked (vertices_checked)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The receiver stalls with a probability of 29 in a hundred, except during the steady
  // stretch where every vertex beat is taken at once.
  always @(negedge clk) begin
    out_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // Watchdog: any accepted beat or register write resets the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  function automatic int eff_span(input logic [8:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIVISIONS) return MAX_DIVISIONS;
    return d;
  endfunction

  // Register write: a setup phase, then an access phase in which the write
  // commits. Random upper bits check that the block masks the value.
  task automatic write_reg(input logic [1:0] reg_id, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_id, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_sphere(input logic [15:0] radius, input logic [8:0] cols,
                            input logic [8:0] rows, input logic inward);
    write_reg(REG_RADIUS, {16'($urandom_range(65535)), radius});
    write_reg(REG_COLUMNS, {16'($urandom_range(65535)), 7'($urandom), cols});
    write_reg(REG_ROWS, {16'($urandom_range(65535)), 7'($urandom), rows});
    write_reg(REG_INWARD, {16'($urandom_range(65535)), 15'($urandom), inward});
    cols_used = eff_span(cols);
    rows_used = eff_span(rows);
  endtask

  // One grid point beat. Valid stays high from one point to the next when no
  // idle cycle is rolled, so back-to-back beats are also exercised.
  task automatic send_point(input logic [8:0] row, input logic [8:0] col,
                            input logic restart);
    while (!steady && $urandom_range(99) < 29) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.grid_row = row;
    in_ch.grid_column = col;
    in_ch.restart_extent = restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every predicted vertex has come out, then let the block settle
  // before the registers change.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (vertices_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    logic [15:0] radius;
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [8:0]  row;
    logic [8:0]  col;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.grid_row = '0;
    in_ch.grid_column = '0;
    in_ch.restart_extent = 1'b0;
    steady = 1'b0;
    rows_used = 16;
    cols_used = 16;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed points on the reset sphere: both poles, the equator, the seam
    // where the column wraps to the divisions, out-of-range points that must
    // clamp, and extent restarts.
    send_point(9'd0, 9'd0, 1'b1);
    send_point(9'd16, 9'd16, 1'b0);
    send_point(9'd8, 9'd0, 1'b0);
    send_point(9'd8, 9'd4, 1'b0);
    send_point(9'd8, 9'd8, 1'b0);
    send_point(9'd8, 9'd12, 1'b0);
    send_point(9'd4, 9'd3, 1'b0);
    send_point(9'd12, 9'd13, 1'b1);
    send_point(9'd256, 9'd256, 1'b0);
    send_point(9'd511, 9'd511, 1'b0);
    send_point(9'd17, 9'd0, 1'b1);
    send_point(9'd0, 9'd17, 1'b0);
    drain();

    // Register extremes: largest radius with the finest grid and inward
    // normals, then zero radius with a single division, then a zero division
    // register and one above the maximum.
    set_sphere(16'd65535, 9'd256, 9'd256, 1'b1);
    send_point(9'd128, 9'd0, 1'b1);
    send_point(9'd128, 9'd64, 1'b0);
    send_point(9'd64, 9'd200, 1'b0);
    send_point(9'd256, 9'd256, 1'b0);
    send_point(9'd0, 9'd255, 1'b0);
    drain();
    set_sphere(16'd0, 9'd1, 9'd1, 1'b0);
    send_point(9'd0, 9'd0, 1'b1);
    send_point(9'd1, 9'd1, 1'b0);
    send_point(9'd511, 9'd0, 1'b0);
    drain();
    set_sphere(16'd1, 9'd0, 9'd511, 1'b1);
    send_point(9'd100, 9'd0, 1'b1);
    send_point(9'd300, 9'd1, 1'b0);
    send_point(9'd256, 9'd5, 1'b0);
    drain();

    // Random phases, each with its own sphere. Most points fall on the grid
    // or just past its edge; a few use the full field range. The third phase
    // runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(4))
        0: radius = 16'd65535;
        1: radius = 16'd0;
        2: radius = 16'd256;
        default: radius = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0: cols = 9'd1;
        1: cols = 9'd256;
        2: cols = 9'd0;
        3: cols = 9'($urandom_range(257, 511));
        default: cols = 9'($urandom_range(2, 255));
      endcase
      case ($urandom_range(5))
        0: rows = 9'd1;
        1: rows = 9'd256;
        2: rows = 9'd0;
        3: rows = 9'($urandom_range(257, 511));
        default: rows = 9'($urandom_range(2, 255));
      endcase
      set_sphere(radius, cols, rows, 1'($urandom));
      steady = (ph == 2);
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        row = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(rows_used + 1));
        col = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(cols_used + 1));
        send_point(row, col, $urandom_range(19) == 0);
      end
      drain();
      steady = 1'b0;
    end

    $display("Covered directed poles, seam and clamped points plus %0d random phases;",
             RANDOM_PHASES);
    $display("%0d vertices checked, %0d still outstanding.", vertices_checked,
             vertices_pending);
    if (mismatch_count == 0 && vertices_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
